// ===== rtl/flvtf_pkg.sv =====
`timescale 1ns / 1ps

package flvtf_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int TAG_HDR_LEN     = 11;
    localparam int TRL_LEN         = 4;

    localparam logic [7:0] CODE_AUDIO = 8'h08;
    localparam logic [7:0] CODE_VIDEO = 8'h09;
    localparam logic [7:0] CODE_META  = 8'h12;
    localparam logic [7:0] CODE_AGGR  = 8'h16;

    // output run slots: 0..10 tag header, 11 body byte, 12..15 trailer
    localparam logic [3:0] IDX_HDR  = 4'd0;
    localparam logic [3:0] IDX_BODY = 4'd11;
    localparam logic [3:0] IDX_TRL  = 4'd12;
    localparam logic [3:0] IDX_LAST = 4'd15;

    localparam logic [2:0] TRL_NONE = 3'd4;

    typedef enum logic [1:0] {
        KIND_AUDIO = 2'd0,
        KIND_VIDEO = 2'd1,
        KIND_META  = 2'd2,
        KIND_AGGR  = 2'd3
    } t_kind;

    function automatic logic [7:0] kind_code(input t_kind kind);
        logic [7:0] code;
        unique case (kind)
            KIND_AUDIO: code = CODE_AUDIO;
            KIND_VIDEO: code = CODE_VIDEO;
            KIND_META:  code = CODE_META;
            KIND_AGGR:  code = CODE_AGGR;
            default:    code = CODE_AUDIO;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] be32_byte(input logic [31:0] v, input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/flv_tag_framer.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake                    tdata                           tuser
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  body_length, timestamp, body_byte  packet_kind
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  out_byte                         corrupt (tlast = end)
//
// One input byte is taken per cycle while its output run fits and m_axis is
// ready: a body byte gives one output byte, the first byte of a media packet
// 12 (tag header), a final byte up to 5 (trailer), a one-byte media packet 16.
// The single output run register sets this.
// Input is taken again in the cycle the last byte of the current run leaves.
// Dropped short packets give no output.
// Reset is synchronous, active low, and clears the packet state and the run.
module flv_tag_framer #(
    parameter int LENGTH_BITS = flvtf_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // body_length[23:0], timestamp[55:24], body_byte[63:56]
    input  logic [1:0]  i_s_axis_tuser,  // packet_kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // out_byte[7:0]
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser   // corrupt[0]
);

    localparam int LB = LENGTH_BITS;
    localparam int TW = 26;

    // packet state
    logic [LB-1:0]        r_pos;
    logic                 r_skip;
    flvtf_pkg::t_kind     r_kind;
    logic [LB-1:0]        r_len;
    logic [31:0]          r_stamp;
    logic [LB:0]          r_tag_start;
    logic [23:0]          r_tag_size;
    logic                 r_size_known;
    logic                 r_overrun;

    // output run
    logic                 r_valid;
    logic [3:0]           r_idx;
    logic [7:0]           r_code;
    logic [23:0]          r_hlen;
    logic [31:0]          r_hstamp;
    logic [7:0]           r_ob;
    logic                 r_beor;
    logic                 r_bcor;
    logic [2:0]           r_trl_from;
    logic [24:0]          r_trl_val;

    logic                 s_acc;
    logic                 m_acc;
    logic                 out_last;

    logic                 p0;
    logic [LB-1:0]        len_raw;
    logic [LB-1:0]        len_in;
    logic [LB-1:0]        n_c;
    flvtf_pkg::t_kind     kind_c;
    logic [31:0]          stamp_c;
    logic                 skip_c;
    logic [LB:0]          ts_c;
    logic [23:0]          sz_c;
    logic                 kn_c;
    logic                 ov_c;
    logic [7:0]           b;
    logic                 last;
    logic [LB-1:0]        n_pos;
    logic [LB:0]          off;
    logic                 in_tag;
    logic [23:0]          size_upd;
    logic [TW-1:0]        t;
    logic [TW-1:0]        p_w;
    logic [TW-1:0]        n_w;
    logic [24:0]          v_agg;
    logic [LB:0]          n_ts;
    logic [23:0]          n_sz;
    logic                 n_kn;
    logic                 n_ov;
    logic [7:0]           n_ob;
    logic [2:0]           n_af;

    logic [3:0]           n_idx;
    logic [7:0]           n_code;
    logic [23:0]          n_hlen;
    logic                 n_beor;
    logic                 n_bcor;
    logic [2:0]           n_trl_from;
    logic [24:0]          n_trl_val;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign out_last = (r_idx == flvtf_pkg::IDX_BODY && r_trl_from == flvtf_pkg::TRL_NONE) ||
                      (r_idx == flvtf_pkg::IDX_LAST);
    assign o_s_axis_tready = !r_valid || (out_last && i_m_axis_tready);

    always_comb begin
        p0      = (r_pos == '0);
        len_raw = i_s_axis_tdata[LB-1:0];
        len_in  = (len_raw == '0) ? LB'(1) : len_raw;
        n_c     = p0 ? len_in : r_len;
        kind_c  = p0 ? flvtf_pkg::t_kind'(i_s_axis_tuser) : r_kind;
        stamp_c = p0 ? i_s_axis_tdata[55:24] : r_stamp;
        skip_c  = p0 ? ((kind_c == flvtf_pkg::KIND_AUDIO && len_in <= LB'(1)) ||
                        (kind_c == flvtf_pkg::KIND_VIDEO && len_in <= LB'(5))) : r_skip;
        ts_c    = p0 ? '0 : r_tag_start;
        sz_c    = p0 ? '0 : r_tag_size;
        kn_c    = p0 ? 1'b0 : r_size_known;
        ov_c    = p0 ? 1'b0 : r_overrun;
        b       = i_s_axis_tdata[63:56];

        last  = ({1'b0, r_pos} + (LB+1)'(1)) >= {1'b0, n_c};
        n_pos = last ? '0 : LB'(r_pos + LB'(1));

        p_w = TW'(r_pos);
        n_w = TW'(n_c);
        off = {1'b0, r_pos} - ts_c;
        in_tag = !ov_c && ((TW'(ts_c) + TW'(flvtf_pkg::TAG_HDR_LEN)) < n_w) &&
                 ({1'b0, r_pos} >= ts_c);
        size_upd = (!kn_c && off >= (LB+1)'(1) && off <= (LB+1)'(3)) ?
                   {sz_c[15:0], b} : sz_c;
        t = TW'(ts_c) + TW'(flvtf_pkg::TAG_HDR_LEN) + TW'(size_upd);
        v_agg = 25'(size_upd) + 25'(flvtf_pkg::TAG_HDR_LEN);

        n_ts = ts_c;
        n_sz = sz_c;
        n_kn = kn_c;
        n_ov = ov_c;
        n_ob = b;
        if (in_tag) begin
            if (!kn_c) begin
                n_sz = size_upd;
                if (off == (LB+1)'(3)) begin
                    n_kn = 1'b1;
                    if (t > n_w) n_ov = 1'b1;
                end
            end else if (p_w >= t && p_w < t + TW'(flvtf_pkg::TRL_LEN)) begin
                n_ob = flvtf_pkg::be32_byte(32'(v_agg), r_pos[1:0] - t[1:0]);
                if (p_w == t + TW'(3)) begin
                    n_ts = (LB+1)'(t + TW'(flvtf_pkg::TRL_LEN));
                    n_sz = '0;
                    n_kn = 1'b0;
                end
            end
        end

        n_af = flvtf_pkg::TRL_NONE;
        if (last && n_kn && !n_ov && (t + TW'(flvtf_pkg::TRL_LEN) > n_w) && t <= n_w) begin
            n_af = {1'b0, n_c[1:0] - t[1:0]};
        end

        n_code = flvtf_pkg::kind_code(kind_c);
        n_hlen = 24'(n_c);
        if (kind_c == flvtf_pkg::KIND_AGGR) begin
            n_idx      = flvtf_pkg::IDX_BODY;
            n_beor     = last && (n_af == flvtf_pkg::TRL_NONE);
            n_bcor     = last && n_ov;
            n_trl_from = n_af;
            n_trl_val  = v_agg;
        end else begin
            n_idx      = p0 ? flvtf_pkg::IDX_HDR : flvtf_pkg::IDX_BODY;
            n_beor     = 1'b0;
            n_bcor     = 1'b0;
            n_trl_from = last ? 3'd0 : flvtf_pkg::TRL_NONE;
            n_trl_val  = 25'(n_c) + 25'(flvtf_pkg::TAG_HDR_LEN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_skip       <= 1'b0;
            r_kind       <= flvtf_pkg::KIND_AUDIO;
            r_len        <= '0;
            r_stamp      <= '0;
            r_tag_start  <= '0;
            r_tag_size   <= '0;
            r_size_known <= 1'b0;
            r_overrun    <= 1'b0;
        end else if (s_acc) begin
            r_pos   <= n_pos;
            r_skip  <= skip_c;
            r_kind  <= kind_c;
            r_len   <= n_c;
            r_stamp <= stamp_c;
            if (kind_c == flvtf_pkg::KIND_AGGR) begin
                r_tag_start  <= n_ts;
                r_tag_size   <= n_sz;
                r_size_known <= n_kn;
                r_overrun    <= n_ov;
            end else begin
                r_tag_start  <= ts_c;
                r_tag_size   <= sz_c;
                r_size_known <= kn_c;
                r_overrun    <= ov_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= flvtf_pkg::IDX_HDR;
        end else if (s_acc && !skip_c) begin
            r_valid <= 1'b1;
            r_idx   <= n_idx;
        end else if (m_acc) begin
            if (out_last) begin
                r_valid <= 1'b0;
            end else if (r_idx == flvtf_pkg::IDX_BODY) begin
                r_idx <= flvtf_pkg::IDX_TRL + {2'b00, r_trl_from[1:0]};
            end else begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && !skip_c) begin
            r_code     <= n_code;
            r_hlen     <= n_hlen;
            r_hstamp   <= stamp_c;
            r_ob       <= n_ob;
            r_beor     <= n_beor;
            r_bcor     <= n_bcor;
            r_trl_from <= n_trl_from;
            r_trl_val  <= n_trl_val;
        end
    end

    always_comb begin
        case (r_idx)
            4'd0:    o_m_axis_tdata = r_code;
            4'd1:    o_m_axis_tdata = r_hlen[23:16];
            4'd2:    o_m_axis_tdata = r_hlen[15:8];
            4'd3:    o_m_axis_tdata = r_hlen[7:0];
            4'd4:    o_m_axis_tdata = r_hstamp[23:16];
            4'd5:    o_m_axis_tdata = r_hstamp[15:8];
            4'd6:    o_m_axis_tdata = r_hstamp[7:0];
            4'd7:    o_m_axis_tdata = r_hstamp[31:24];
            4'd8, 4'd9, 4'd10: o_m_axis_tdata = 8'h00;
            4'd11:   o_m_axis_tdata = r_ob;
            default: o_m_axis_tdata = flvtf_pkg::be32_byte(32'(r_trl_val), r_idx[1:0]);
        endcase
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tlast  = (r_idx == flvtf_pkg::IDX_LAST) ||
                             (r_idx == flvtf_pkg::IDX_BODY && r_beor);
    assign o_m_axis_tuser  = (r_idx == flvtf_pkg::IDX_BODY) && r_bcor;

endmodule

// ===== rtl/flvtf_checker.sv =====
`timescale 1ns / 1ps

module flvtf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic       o_m_axis_tuser
);

    // corrupt mark only on the final byte of a packet
    a_corrupt_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("corrupt set on a byte that is not last");

    // a stalled output run blocks new input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while output stalled");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output item dropped while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind flv_tag_framer flvtf_checker u_flvtf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
